>>> rtl/ptm_pkg.sv
// Package for the PBR neutral tone mapper: shared constants, config codes and types.
// No dependencies; every other file of the block depends on it.
package ptm_pkg;

    localparam int IN_WIDTH_DEF   = 24;
    localparam int OUT_WIDTH_DEF  = 16;
    localparam int FRAC           = 16;
    localparam int Q_WIDTH        = 17;   // quotient bits of every divider, covers 0..65536
    localparam int TOE_W          = 13;   // toe only active below 0.08, fits 13 bits
    localparam int NUMQ_W         = 34;   // k*k plus rounding term
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 16;

    localparam logic [16:0]      ONE_Q16    = 17'h10000;
    localparam logic [TOE_W-1:0] TOE_LIMIT  = 13'd5243;
    localparam logic [TOE_W-1:0] TOE_FLAT   = 13'd2621;
    localparam logic [15:0]      CS_RESET   = 16'd49807;
    localparam logic [15:0]      DS_RESET   = 16'd9830;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_COMPRESSION_START = 2'd0,
        CFG_DESAT_STRENGTH    = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] compression_start;
        logic [15:0] desaturation_strength;
    } cfg_t;

endpackage

>>> rtl/ptm_ifs.sv
// Channel interfaces of the tone mapper: pixel in, pixel out, config writes.
// Depends on ptm_pkg for default widths.
interface ptm_pix_in_if #(parameter int W = ptm_pkg::IN_WIDTH_DEF);
    logic         valid;
    logic         ready;
    logic [W-1:0] red_in;
    logic [W-1:0] green_in;
    logic [W-1:0] blue_in;
    modport source (output valid, output red_in, output green_in, output blue_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface ptm_pix_out_if #(parameter int W = ptm_pkg::OUT_WIDTH_DEF);
    logic         valid;
    logic         ready;
    logic [W-1:0] red_out;
    logic [W-1:0] green_out;
    logic [W-1:0] blue_out;
    modport source (output valid, output red_out, output green_out, output blue_out, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

interface ptm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ptm_pkg::CFG_IDX_WIDTH-1:0]   index;
    logic [ptm_pkg::CFG_DATA_WIDTH-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/pbr_neutral_tonemap.sv
// PBR neutral tone mapper, fully pipelined: one pixel per clock while the output buffer
// has room. The depth is set by the two 18-stage bit-per-stage dividers
// (compression ratio, then scale and desaturation weight) plus eight other stages.
// A whole-pipeline stall happens only when the two-entry output buffer is full.
// Reset (rst_n low, async) clears valid bits and the buffer and loads the config
// defaults 0.76 and 0.15. Depends on ptm_pkg, ptm_ifs, ptm_prep, ptm_div, ptm_blend.
module pbr_neutral_tonemap #(
    parameter int IN_WIDTH  = ptm_pkg::IN_WIDTH_DEF,
    parameter int OUT_WIDTH = ptm_pkg::OUT_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ptm_cfg_if.sink       cfg,
    ptm_pix_in_if.sink    pix_in,
    ptm_pix_out_if.source pix_out
);
    import ptm_pkg::*;

    localparam int W    = IN_WIDTH;
    localparam int O    = OUT_WIDTH;
    localparam int DLAT = Q_WIDTH + 1;

    // configuration registers
    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.compression_start     <= CS_RESET;
            cfg_reg.desaturation_strength <= DS_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_COMPRESSION_START)
            begin
                cfg_reg.compression_start <= cfg.data;
            end
            else if (cfg.index == CFG_DESAT_STRENGTH)
            begin
                cfg_reg.desaturation_strength <= cfg.data;
            end
        end
    end

    // output buffer state; pipeline advances while it has room
    logic [1:0] fifo_cnt_reg;
    logic [1:0] fifo_cnt_next;
    logic       en;
    logic       push;
    logic       pop;

    assign en           = (fifo_cnt_reg != 2'd2);
    assign pix_in.ready = en;

    // front stages
    logic [2:0][W-1:0]   in_c;
    logic                p_valid;
    logic [2:0][W-1:0]   p_c;
    logic [W-1:0]        p_b;
    logic                p_lin;
    logic [W:0]          p_den;
    logic [NUMQ_W-1:0]   p_num;

    assign in_c = {pix_in.blue_in, pix_in.green_in, pix_in.red_in};

    ptm_prep #(.IN_WIDTH(W)) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pix_in.valid),
        .in_c      (in_c),
        .cfg       (cfg_reg),
        .out_valid (p_valid),
        .out_c     (p_c),
        .out_b     (p_b),
        .out_lin   (p_lin),
        .out_den   (p_den),
        .out_num   (p_num)
    );

    logic [Q_WIDTH-1:0] q;

    ptm_div #(.NW(NUMQ_W), .DW(W+1), .QW(Q_WIDTH)) u_div_q (
        .clk (clk),
        .en  (en),
        .num (p_num),
        .den (p_den),
        .quo (q)
    );

    // sideband alongside the first divider
    logic              sb1_valid_reg [DLAT];
    logic              sb1_lin_reg   [DLAT];
    logic [W-1:0]      sb1_b_reg     [DLAT];
    logic [2:0][W-1:0] sb1_c_reg     [DLAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DLAT; i++)
            begin
                sb1_valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            sb1_valid_reg[0] <= p_valid;
            for (int i = 1; i < DLAT; i++)
            begin
                sb1_valid_reg[i] <= sb1_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb1_lin_reg[0] <= p_lin;
            sb1_b_reg[0]   <= p_b;
            sb1_c_reg[0]   <= p_c;
            for (int i = 1; i < DLAT; i++)
            begin
                sb1_lin_reg[i] <= sb1_lin_reg[i-1];
                sb1_b_reg[i]   <= sb1_b_reg[i-1];
                sb1_c_reg[i]   <= sb1_c_reg[i-1];
            end
        end
    end

    // stage D: compressed peak and excess over it
    logic [16:0] nb;
    logic [W:0]  bx;
    logic [W:0]  nbx;

    always_comb
    begin
        nb  = q[16] ? 17'd0 : (ONE_Q16 - q);
        bx  = (W+1)'(sb1_b_reg[DLAT-1]);
        nbx = (W+1)'(nb);
    end

    logic              d_valid_reg, e_valid_reg, f_valid_reg;
    logic              d_lin_reg, e_lin_reg, f_lin_reg;
    logic [W-1:0]      d_b_reg, e_b_reg, f_b_reg;
    logic [2:0][W-1:0] d_c_reg, e_c_reg, f_c_reg;
    logic [16:0]       d_nb_reg, e_nb_reg, f_nb_reg;
    logic [W-1:0]      d_diff_reg;
    logic [W+15:0]     e_pt_reg;
    logic [2:0][W+16:0] e_pc_reg;
    logic [W:0]        f_den_w_reg;
    logic [W+16:0]     f_num_w_reg;
    logic [2:0][W+17:0] f_num_s_reg;

    // stage F operands
    logic [W+16:0] ptr;
    logic [W:0]    t;
    logic [W:0]    den_w;

    always_comb
    begin
        ptr   = (W+17)'(e_pt_reg) + (W+17)'(32'h8000);
        t     = ptr[W+16:16];
        den_w = t + (W+1)'(ONE_Q16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= sb1_valid_reg[DLAT-1];
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_lin_reg  <= sb1_lin_reg[DLAT-1];
            d_b_reg    <= sb1_b_reg[DLAT-1];
            d_c_reg    <= sb1_c_reg[DLAT-1];
            d_nb_reg   <= nb;
            d_diff_reg <= (bx > nbx) ? W'(bx - nbx) : '0;

            e_lin_reg <= d_lin_reg;
            e_b_reg   <= d_b_reg;
            e_c_reg   <= d_c_reg;
            e_nb_reg  <= d_nb_reg;
            e_pt_reg  <= (W+16)'(cfg_reg.desaturation_strength) * (W+16)'(d_diff_reg);
            for (int i = 0; i < 3; i++)
            begin
                e_pc_reg[i] <= (W+17)'(d_c_reg[i]) * (W+17)'(d_nb_reg);
            end

            f_lin_reg   <= e_lin_reg;
            f_b_reg     <= e_b_reg;
            f_c_reg     <= e_c_reg;
            f_nb_reg    <= e_nb_reg;
            f_den_w_reg <= den_w;
            f_num_w_reg <= {t[W:0], 16'd0} + (W+17)'(den_w >> 1);
            for (int i = 0; i < 3; i++)
            begin
                f_num_s_reg[i] <= (W+18)'(e_pc_reg[i]) + (W+18)'(e_b_reg >> 1);
            end
        end
    end

    // weight and per-channel scale dividers, running side by side
    logic [Q_WIDTH-1:0]      w;
    logic [2:0][Q_WIDTH-1:0] s;

    ptm_div #(.NW(W+17), .DW(W+1), .QW(Q_WIDTH)) u_div_w (
        .clk (clk),
        .en  (en),
        .num (f_num_w_reg),
        .den (f_den_w_reg),
        .quo (w)
    );

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_scale
        ptm_div #(.NW(W+18), .DW(W), .QW(Q_WIDTH)) u_div_s (
            .clk (clk),
            .en  (en),
            .num (f_num_s_reg[ch]),
            .den (f_b_reg),
            .quo (s[ch])
        );
    end

    logic              sb2_valid_reg [DLAT];
    logic              sb2_lin_reg   [DLAT];
    logic [W-1:0]      sb2_b_reg     [DLAT];
    logic [16:0]       sb2_nb_reg    [DLAT];
    logic [2:0][W-1:0] sb2_c_reg     [DLAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DLAT; i++)
            begin
                sb2_valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            sb2_valid_reg[0] <= f_valid_reg;
            for (int i = 1; i < DLAT; i++)
            begin
                sb2_valid_reg[i] <= sb2_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb2_lin_reg[0] <= f_lin_reg;
            sb2_b_reg[0]   <= f_b_reg;
            sb2_nb_reg[0]  <= f_nb_reg;
            sb2_c_reg[0]   <= f_c_reg;
            for (int i = 1; i < DLAT; i++)
            begin
                sb2_lin_reg[i] <= sb2_lin_reg[i-1];
                sb2_b_reg[i]   <= sb2_b_reg[i-1];
                sb2_nb_reg[i]  <= sb2_nb_reg[i-1];
                sb2_c_reg[i]   <= sb2_c_reg[i-1];
            end
        end
    end

    logic              g_valid;
    logic [2:0][O-1:0] g_pix;

    ptm_blend #(.IN_WIDTH(W), .OUT_WIDTH(O)) u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sb2_valid_reg[DLAT-1]),
        .in_lin    (sb2_lin_reg[DLAT-1]),
        .in_b      (sb2_b_reg[DLAT-1]),
        .in_nb     (sb2_nb_reg[DLAT-1]),
        .in_c      (sb2_c_reg[DLAT-1]),
        .in_w      (w),
        .in_s      (s),
        .out_valid (g_valid),
        .out_pix   (g_pix)
    );

    // two-entry output buffer
    logic [3*O-1:0] fifo_mem [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;

    assign push          = en && g_valid;
    assign pop           = pix_out.valid && pix_out.ready;
    assign fifo_cnt_next = fifo_cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_cnt_reg <= 2'd0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
        end
        else
        begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= g_pix;
        end
    end

    assign pix_out.valid     = (fifo_cnt_reg != 2'd0);
    assign pix_out.red_out   = fifo_mem[rd_ptr_reg][O-1:0];
    assign pix_out.green_out = fifo_mem[rd_ptr_reg][2*O-1:O];
    assign pix_out.blue_out  = fifo_mem[rd_ptr_reg][3*O-1:2*O];

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= 2'd2)
        else $error("output buffer count out of range");

    a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (fifo_cnt_reg == $past(fifo_cnt_reg) + 2'd1))
        else $error("output buffer count missed a push");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (fifo_cnt_reg != 2'd0))
        else $error("pop from empty output buffer");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(sb2_valid_reg[DLAT-1]))
        else $error("pipeline moved during stall");

endmodule

>>> rtl/ptm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ptm_pkg for the default quotient width.
module ptm_div #(
    parameter int NW = 34,
    parameter int DW = 25,
    parameter int QW = ptm_pkg::Q_WIDTH
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);
    import ptm_pkg::*;

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] rem_reg [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    logic [QW-1:0] quo_reg [QW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_step
        logic [CW-1:0] trial;
        logic [CW-1:0] remx;
        logic          ge;

        always_comb
        begin
            trial = CW'(den_reg[j-1]) << (QW - j);
            remx  = CW'(rem_reg[j-1]);
            ge    = (remx >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? NW'(remx - trial) : rem_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                quo_reg[j] <= {quo_reg[j-1][QW-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[QW];

endmodule

>>> rtl/ptm_prep.sv
// Front stages: darkest channel, toe offset, brightest channel, compression divide operands.
// Depends on ptm_pkg.
module ptm_prep #(
    parameter int IN_WIDTH = ptm_pkg::IN_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [2:0][IN_WIDTH-1:0]          in_c,
    input  ptm_pkg::cfg_t                     cfg,
    output logic                              out_valid,
    output logic [2:0][IN_WIDTH-1:0]          out_c,
    output logic [IN_WIDTH-1:0]               out_b,
    output logic                              out_lin,
    output logic [IN_WIDTH:0]                 out_den,
    output logic [ptm_pkg::NUMQ_W-1:0]        out_num
);
    import ptm_pkg::*;

    localparam int W = IN_WIDTH;

    // stage A: minimum and square
    logic [W-1:0]           d;
    logic                   d_lt;
    logic [2*TOE_W-1:0]     sq;
    logic                   a_valid_reg;
    logic [2:0][W-1:0]      a_c_reg;
    logic                   a_lt_reg;
    logic [TOE_W-1:0]       a_d_reg;
    logic [2*TOE_W-1:0]     a_sq_reg;

    always_comb
    begin
        d = in_c[0];
        if (in_c[1] < d)
        begin
            d = in_c[1];
        end
        if (in_c[2] < d)
        begin
            d = in_c[2];
        end
        d_lt = (d < W'(TOE_LIMIT));
        sq   = (2*TOE_W)'(d[TOE_W-1:0]) * (2*TOE_W)'(d[TOE_W-1:0]);
    end

    // stage B: toe offset subtracted
    logic [30:0]            sc;
    logic [TOE_W-1:0]       off;
    logic                   b_valid_reg;
    logic [2:0][W-1:0]      b_c_reg;

    always_comb
    begin
        sc  = 31'(a_sq_reg) * 31'd25 + 31'h20000;
        off = a_lt_reg ? (a_d_reg - sc[30:18]) : TOE_FLAT;
    end

    // stage C: brightest channel and divide operands
    logic [W-1:0]           bmax;
    logic [16:0]            k;
    logic [W:0]             den;
    logic [NUMQ_W-1:0]      kk;

    always_comb
    begin
        bmax = b_c_reg[0];
        if (b_c_reg[1] > bmax)
        begin
            bmax = b_c_reg[1];
        end
        if (b_c_reg[2] > bmax)
        begin
            bmax = b_c_reg[2];
        end
        k   = ONE_Q16 - {1'b0, cfg.compression_start};
        den = (W+1)'(bmax) + (W+1)'(k) - (W+1)'(cfg.compression_start);
        kk  = NUMQ_W'(k) * NUMQ_W'(k);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            out_valid   <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            out_valid   <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_c_reg  <= in_c;
            a_lt_reg <= d_lt;
            a_d_reg  <= d[TOE_W-1:0];
            a_sq_reg <= sq;
            for (int i = 0; i < 3; i++)
            begin
                b_c_reg[i] <= a_c_reg[i] - W'(off);
            end
            out_c   <= b_c_reg;
            out_b   <= bmax;
            out_lin <= (bmax < W'(cfg.compression_start));
            out_den <= den;
            out_num <= kk + NUMQ_W'(den >> 1);
        end
    end

endmodule

>>> rtl/ptm_blend.sv
// Back stages: desaturation blend products, rounding and saturation to output codes.
// Depends on ptm_pkg.
module ptm_blend #(
    parameter int IN_WIDTH  = ptm_pkg::IN_WIDTH_DEF,
    parameter int OUT_WIDTH = ptm_pkg::OUT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic                                in_lin,
    input  logic [IN_WIDTH-1:0]                 in_b,
    input  logic [16:0]                         in_nb,
    input  logic [2:0][IN_WIDTH-1:0]            in_c,
    input  logic [ptm_pkg::Q_WIDTH-1:0]         in_w,
    input  logic [2:0][ptm_pkg::Q_WIDTH-1:0]    in_s,
    output logic                                out_valid,
    output logic [2:0][OUT_WIDTH-1:0]           out_pix
);
    import ptm_pkg::*;

    localparam int W  = IN_WIDTH;
    localparam int O  = OUT_WIDTH;
    localparam int XW = (W > 19) ? W : 19;
    localparam int SH = FRAC - O;

    function automatic logic [O-1:0] to_out(input logic [XW-1:0] x);
        logic [XW+1:0] y;
        y = ((XW+2)'({x, 1'b0}) >> SH) + (XW+2)'(1);
        y = y >> 1;
        if (y > (XW+2)'((1 << O) - 1))
        begin
            return {O{1'b1}};
        end
        return y[O-1:0];
    endfunction

    logic [2:0][Q_WIDTH-1:0] s_fix;
    logic [16:0]             omw;
    logic                    g_valid_reg;
    logic                    g_lin_reg;
    logic [2:0][W-1:0]       g_c_reg;
    logic [2:0][33:0]        g_p1_reg;
    logic [33:0]             g_p2_reg;

    always_comb
    begin
        // zero brightness: ratio undefined, scaled channels taken as zero
        for (int i = 0; i < 3; i++)
        begin
            s_fix[i] = (in_b == '0) ? '0 : in_s[i];
        end
        omw = ONE_Q16 - in_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            g_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_lin_reg <= in_lin;
            g_c_reg   <= in_c;
            for (int i = 0; i < 3; i++)
            begin
                g_p1_reg[i] <= 34'(s_fix[i]) * 34'(omw);
            end
            g_p2_reg <= 34'(in_nb) * 34'(in_w);
        end
    end

    logic [34:0] sum [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum[i] = 35'(g_p1_reg[i]) + 35'(g_p2_reg) + 35'h8000;
            out_pix[i] = g_lin_reg ? to_out(XW'(g_c_reg[i])) : to_out(XW'(sum[i][34:16]));
        end
    end

    assign out_valid = g_valid_reg;

endmodule
